/* hw/rtl/bcbs_pkg.sv */
// types and constants shared by the bit cursor byte store modules
package bcbs_pkg;

    localparam int unsigned CURSOR_W = 11;
    localparam int unsigned OFF_W    = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned PAIR_W   = 2 * BYTE_W;

    localparam logic [OFF_W-1:0]  LAST_BIT     = 3'd7;
    localparam logic [PAIR_W-1:0] BYTE_MASK_HI = 16'hFF00;
    localparam logic [PAIR_W-1:0] BIT_MASK_HI  = 16'h8000;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_READ_BIT   = 3'd0,
        CMD_READ_BYTE  = 3'd1,
        CMD_WRITE_BIT  = 3'd2,
        CMD_WRITE_BYTE = 3'd3,
        CMD_REWIND     = 3'd4
    } cmd_t;

    // decision taken for one item when it is accepted
    typedef struct packed {
        logic                ok;
        logic                access;
        logic                is_write;
        logic                is_byte;
        logic [OFF_W-1:0]    off;
        logic [CURSOR_W-1:0] cursor;
        logic [CURSOR_W-1:0] next_byte;
        logic [OFF_W-1:0]    next_bit;
    } acc_t;

    // write-back request from the merge logic
    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [BYTE_W-1:0] new_a;
        logic [BYTE_W-1:0] new_b;
    } wb_t;

endpackage

/* hw/rtl/bcbs_bank.sv */
// one bank of the byte store: synchronous read, one write port
module bcbs_bank #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned ROW_W = 9
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [ROW_W-1:0]           rd_row,
    output logic [bcbs_pkg::BYTE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [ROW_W-1:0]           wr_row,
    input  logic [bcbs_pkg::BYTE_W-1:0] wr_data
);
    import bcbs_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
    end

    // registered read, old data on a same-row write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bcbs_cursor.sv */
// stream length register, bit cursor and per-item access decision
module bcbs_cursor #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bcbs_pkg::CURSOR_W-1:0] cfg_wr_data,
    input  logic                          advance,
    input  logic [bcbs_pkg::CMD_W-1:0]    command,
    output bcbs_pkg::acc_t                acc
);
    import bcbs_pkg::*;

    logic [CURSOR_W-1:0] stream_length_reg;
    logic [CURSOR_W-1:0] byte_cursor_reg;
    logic [OFF_W-1:0]    bit_cursor_reg;
    logic [CURSOR_W-1:0] eff_len;
    logic [CURSOR_W:0]   cur_p1;
    logic                cur_in;
    logic                next_in;
    cmd_t                cmd;

    assign cmd = cmd_t'(command);

    // length in effect is capped by the store size
    always_comb begin
        if (32'(stream_length_reg) < STORE_BYTES) begin
            eff_len = stream_length_reg;
        end else begin
            eff_len = CURSOR_W'(STORE_BYTES);
        end
    end

    assign cur_p1  = {1'b0, byte_cursor_reg} + {{CURSOR_W{1'b0}}, 1'b1};
    assign cur_in  = byte_cursor_reg < eff_len;
    assign next_in = cur_p1 < {1'b0, eff_len};

    // decode the command against the cursor
    always_comb begin
        acc           = '0;
        acc.off       = bit_cursor_reg;
        acc.cursor    = byte_cursor_reg;
        acc.next_byte = byte_cursor_reg;
        acc.next_bit  = bit_cursor_reg;
        unique case (cmd)
            CMD_READ_BIT, CMD_WRITE_BIT: begin
                acc.is_write = (cmd == CMD_WRITE_BIT);
                if (cur_in) begin
                    acc.ok     = 1'b1;
                    acc.access = 1'b1;
                    if (bit_cursor_reg == LAST_BIT) begin
                        acc.next_bit  = '0;
                        acc.next_byte = cur_p1[CURSOR_W-1:0];
                    end else begin
                        acc.next_bit = bit_cursor_reg + 1'b1;
                    end
                end
            end
            CMD_READ_BYTE, CMD_WRITE_BYTE: begin
                acc.is_write = (cmd == CMD_WRITE_BYTE);
                acc.is_byte  = 1'b1;
                if ((bit_cursor_reg == '0) ? cur_in : next_in) begin
                    acc.ok        = 1'b1;
                    acc.access    = 1'b1;
                    acc.next_byte = cur_p1[CURSOR_W-1:0];
                end
            end
            CMD_REWIND: begin
                acc.ok        = 1'b1;
                acc.next_byte = '0;
                acc.next_bit  = '0;
            end
            default: begin
                acc.ok = 1'b0;
            end
        endcase
    end

    // cursor moves when an item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cursor_reg <= '0;
            bit_cursor_reg  <= '0;
        end else if (advance) begin
            byte_cursor_reg <= acc.next_byte;
            bit_cursor_reg  <= acc.next_bit;
        end
    end

    // stream length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_length_reg <= '0;
        end else if (cfg_wr_en) begin
            stream_length_reg <= cfg_wr_data;
        end
    end

endmodule

/* hw/rtl/bcbs_merge.sv */
// read extraction and bit/byte merge over the two bytes under the cursor
module bcbs_merge (
    input  bcbs_pkg::acc_t              acc,
    input  logic [bcbs_pkg::BYTE_W-1:0] write_value,
    input  logic [bcbs_pkg::BYTE_W-1:0] byte_a,
    input  logic [bcbs_pkg::BYTE_W-1:0] byte_b,
    output logic [bcbs_pkg::BYTE_W-1:0] read_value,
    output bcbs_pkg::wb_t               wb
);
    import bcbs_pkg::*;

    logic [PAIR_W-1:0] pair;
    logic [PAIR_W-1:0] aligned;
    logic [PAIR_W-1:0] mask;
    logic [PAIR_W-1:0] data;
    logic [PAIR_W-1:0] merged;

    assign pair    = {byte_a, byte_b};
    assign aligned = pair << acc.off;

    // field covered by the access, MSB first from the cursor
    always_comb begin
        if (acc.is_byte) begin
            mask = BYTE_MASK_HI >> acc.off;
            data = {write_value, {BYTE_W{1'b0}}} >> acc.off;
        end else begin
            mask = BIT_MASK_HI >> acc.off;
            data = (write_value != '0) ? mask : '0;
        end
    end

    assign merged = (pair & ~mask) | data;

    // read value, zero for writes and failures
    always_comb begin
        if (!acc.access || acc.is_write) begin
            read_value = '0;
        end else if (acc.is_byte) begin
            read_value = aligned[PAIR_W-1:BYTE_W];
        end else begin
            read_value = {{(BYTE_W-1){1'b0}}, aligned[PAIR_W-1]};
        end
    end

    // second byte only touched by an unaligned byte write
    assign wb.we_a  = acc.access && acc.is_write;
    assign wb.we_b  = wb.we_a && acc.is_byte && (acc.off != '0);
    assign wb.new_a = merged[PAIR_W-1:BYTE_W];
    assign wb.new_b = merged[BYTE_W-1:0];

endmodule

/* hw/rtl/bit_cursor_byte_store_core.sv */
// top level: bit cursor over a byte store held in an even and an odd bank
// path: an accepted item passes the read stage registers, then the output register,
// where its result is offered until it is taken
// throughput: one item per cycle while the result side does not stall; both bytes of an
// unaligned access come from the two banks in one read, and write-back is forwarded to the next item
// reset: cursor, length and handshakes clear at once, then a clearing pass zeroes
// both banks row by row; no item is taken until it ends
module bit_cursor_byte_store_core #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bcbs_pkg::CURSOR_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bcbs_pkg::CMD_W-1:0]    s_command,
    input  logic [bcbs_pkg::BYTE_W-1:0]   s_write_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [bcbs_pkg::BYTE_W-1:0]   m_read_value,
    output logic [bcbs_pkg::CURSOR_W-1:0] m_byte_position,
    output logic [bcbs_pkg::OFF_W-1:0]    m_bit_position
);
    import bcbs_pkg::*;

    localparam int unsigned BANK_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int unsigned XW         = (ROW_W > CURSOR_W) ? ROW_W : CURSOR_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

    acc_t acc;
    logic accept;
    logic b_adv;

    // clearing pass state
    logic             clr_active_reg;
    logic [ROW_W-1:0] clr_row_reg;

    // read stage
    logic              b_valid_reg;
    acc_t              b_acc_reg;
    logic [BYTE_W-1:0] b_wv_reg;
    logic [ROW_W-1:0]  b_even_row_reg;
    logic [ROW_W-1:0]  b_odd_row_reg;

    // bank ports
    logic [CURSOR_W:0] cur_p1;
    logic [XW-1:0]     even_row_x;
    logic [XW-1:0]     odd_row_x;
    logic [ROW_W-1:0]  even_rd_row;
    logic [ROW_W-1:0]  odd_rd_row;
    logic [BYTE_W-1:0] even_rdata;
    logic [BYTE_W-1:0] odd_rdata;
    logic              even_we;
    logic              odd_we;
    logic [ROW_W-1:0]  even_wr_row;
    logic [ROW_W-1:0]  odd_wr_row;
    logic [BYTE_W-1:0] even_wr_data;
    logic [BYTE_W-1:0] odd_wr_data;
    logic              even_item_we;
    logic              odd_item_we;

    // forwarding of the last write to each bank
    logic              fwd_even_valid_reg;
    logic [ROW_W-1:0]  fwd_even_row_reg;
    logic [BYTE_W-1:0] fwd_even_data_reg;
    logic              fwd_odd_valid_reg;
    logic [ROW_W-1:0]  fwd_odd_row_reg;
    logic [BYTE_W-1:0] fwd_odd_data_reg;
    logic [BYTE_W-1:0] even_q;
    logic [BYTE_W-1:0] odd_q;

    // merge
    logic              a_in_odd;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic [BYTE_W-1:0] rd_value;
    wb_t               wb;

    // output register
    logic                m_valid_reg;
    logic                m_ok_reg;
    logic [BYTE_W-1:0]   m_read_value_reg;
    logic [CURSOR_W-1:0] m_byte_position_reg;
    logic [OFF_W-1:0]    m_bit_position_reg;

    // handshake
    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clr_active_reg && (!b_valid_reg || b_adv);
    assign accept  = s_valid && s_ready;

    bcbs_cursor #(
        .STORE_BYTES (STORE_BYTES)
    ) u_cursor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (accept),
        .command     (s_command),
        .acc         (acc)
    );

    // byte k sits in bank k[0] at row k/2; the cursor byte and the next one
    // always fall in different banks
    assign cur_p1      = {1'b0, acc.cursor} + {{CURSOR_W{1'b0}}, 1'b1};
    assign even_row_x  = XW'(cur_p1 >> 1);
    assign odd_row_x   = XW'(acc.cursor >> 1);
    assign even_rd_row = even_row_x[ROW_W-1:0];
    assign odd_rd_row  = odd_row_x[ROW_W-1:0];

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_row_reg == LAST_ROW) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    // read stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_acc_reg      <= acc;
            b_wv_reg       <= s_write_value;
            b_even_row_reg <= even_rd_row;
            b_odd_row_reg  <= odd_rd_row;
        end
    end

    // pick forwarded data over the array when the row was just written
    assign even_q = (fwd_even_valid_reg && fwd_even_row_reg == b_even_row_reg)
                    ? fwd_even_data_reg : even_rdata;
    assign odd_q  = (fwd_odd_valid_reg && fwd_odd_row_reg == b_odd_row_reg)
                    ? fwd_odd_data_reg : odd_rdata;

    assign a_in_odd = b_acc_reg.cursor[0];
    assign byte_a   = a_in_odd ? odd_q : even_q;
    assign byte_b   = a_in_odd ? even_q : odd_q;

    bcbs_merge u_merge (
        .acc         (b_acc_reg),
        .write_value (b_wv_reg),
        .byte_a      (byte_a),
        .byte_b      (byte_b),
        .read_value  (rd_value),
        .wb          (wb)
    );

    // write-back steering, the clearing pass takes both banks
    assign even_item_we = b_adv && (a_in_odd ? wb.we_b : wb.we_a);
    assign odd_item_we  = b_adv && (a_in_odd ? wb.we_a : wb.we_b);

    assign even_we      = clr_active_reg || even_item_we;
    assign odd_we       = clr_active_reg || odd_item_we;
    assign even_wr_row  = clr_active_reg ? clr_row_reg : b_even_row_reg;
    assign odd_wr_row   = clr_active_reg ? clr_row_reg : b_odd_row_reg;
    assign even_wr_data = clr_active_reg ? '0 : (a_in_odd ? wb.new_b : wb.new_a);
    assign odd_wr_data  = clr_active_reg ? '0 : (a_in_odd ? wb.new_a : wb.new_b);

    bcbs_bank #(
        .DEPTH (BANK_DEPTH),
        .ROW_W (ROW_W)
    ) u_even_bank (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_row  (even_rd_row),
        .rd_data (even_rdata),
        .wr_en   (even_we),
        .wr_row  (even_wr_row),
        .wr_data (even_wr_data)
    );

    bcbs_bank #(
        .DEPTH (BANK_DEPTH),
        .ROW_W (ROW_W)
    ) u_odd_bank (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_row  (odd_rd_row),
        .rd_data (odd_rdata),
        .wr_en   (odd_we),
        .wr_row  (odd_wr_row),
        .wr_data (odd_wr_data)
    );

    // forwarding registers track the last item write per bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_even_valid_reg <= 1'b0;
            fwd_odd_valid_reg  <= 1'b0;
        end else begin
            if (even_item_we) begin
                fwd_even_valid_reg <= 1'b1;
            end
            if (odd_item_we) begin
                fwd_odd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (even_item_we) begin
            fwd_even_row_reg  <= b_even_row_reg;
            fwd_even_data_reg <= even_wr_data;
        end
        if (odd_item_we) begin
            fwd_odd_row_reg  <= b_odd_row_reg;
            fwd_odd_data_reg <= odd_wr_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_ok_reg            <= b_acc_reg.ok;
            m_read_value_reg    <= rd_value;
            m_byte_position_reg <= b_acc_reg.next_byte;
            m_bit_position_reg  <= b_acc_reg.next_bit;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_byte_position = m_byte_position_reg;
    assign m_bit_position  = m_bit_position_reg;

    // no item enters while the banks are being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("item taken during clearing pass");

    // cursor only moves with an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(acc.cursor) && $stable(acc.off))
        else $error("cursor moved without an item");

    // both banks written by one item only for an unaligned byte write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (even_item_we && odd_item_we) |-> (b_acc_reg.is_byte && b_acc_reg.off != '0))
        else $error("two-bank write from a non-spanning access");

    // an accepted item sits in the read stage on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> b_valid_reg)
        else $error("accepted item lost before read stage");

endmodule

/* bench/bcbs_cursor_checker.sv */
// predicts and checks every result of the bit cursor byte store from its two channels
module bcbs_cursor_checker #(
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bcbs_pkg::CURSOR_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [bcbs_pkg::CMD_W-1:0]    s_command,
    input  logic [bcbs_pkg::BYTE_W-1:0]   s_write_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_ok,
    input  logic [bcbs_pkg::BYTE_W-1:0]   m_read_value,
    input  logic [bcbs_pkg::CURSOR_W-1:0] m_byte_position,
    input  logic [bcbs_pkg::OFF_W-1:0]    m_bit_position,
    output int unsigned                   fail_count,
    output int unsigned                   outstanding,
    output int unsigned                   checked_count,
    output int unsigned                   refused_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bcbs_pkg::*;

    // one result as the block should report it
    typedef struct packed {
        logic                ok;
        logic [BYTE_W-1:0]   read_value;
        logic [CURSOR_W-1:0] byte_pos;
        logic [OFF_W-1:0]    bit_pos;
    } reply_t;

    // shadow copy of the store, cursor and length register
    logic [BYTE_W-1:0]   store_image [STORE_BYTES];
    logic [CURSOR_W-1:0] cur_byte;
    logic [OFF_W-1:0]    cur_bit;
    logic [CURSOR_W-1:0] stream_len;
    reply_t              pending_replies [$];

    // carry out one command on the shadow state and report its result
    task automatic step_cursor_model(
        input  logic [CMD_W-1:0]  cmd,
        input  logic [BYTE_W-1:0] wv,
        output reply_t            reply
    );
        int unsigned       lim;
        int unsigned       here;
        int unsigned       off;
        logic [PAIR_W-1:0] pair;
        logic [PAIR_W-1:0] span;
        lim   = (32'(stream_len) < STORE_BYTES) ? 32'(stream_len) : STORE_BYTES;
        here  = 32'(cur_byte);
        off   = 32'(cur_bit);
        reply = '0;
        case (cmd)
            CMD_READ_BIT, CMD_WRITE_BIT: begin
                if (here < lim) begin
                    if (cmd == CMD_READ_BIT) begin
                        reply.read_value = {{(BYTE_W-1){1'b0}},
                                            store_image[here][LAST_BIT - off]};
                    end else begin
                        store_image[here][LAST_BIT - off] = (wv != '0);
                    end
                    reply.ok = 1'b1;
                    // msb first, wrap into the next byte after the lsb
                    if (cur_bit == LAST_BIT) begin
                        cur_bit  = '0;
                        cur_byte = cur_byte + 1'b1;
                    end else begin
                        cur_bit = cur_bit + 1'b1;
                    end
                end
            end
            CMD_READ_BYTE, CMD_WRITE_BYTE: begin
                if (off == 0) begin
                    // aligned: one store byte, must lie inside the stream
                    if (here < lim) begin
                        if (cmd == CMD_READ_BYTE) begin
                            reply.read_value = store_image[here];
                        end else begin
                            store_image[here] = wv;
                        end
                        reply.ok = 1'b1;
                        cur_byte = cur_byte + 1'b1;
                    end
                end else if (here + 1 < lim) begin
                    // unaligned: low bits of this byte and high bits of the next
                    pair = {store_image[here], store_image[here + 1]};
                    span = BYTE_MASK_HI >> off;
                    if (cmd == CMD_READ_BYTE) begin
                        reply.read_value = pair[PAIR_W - 1 - off -: BYTE_W];
                    end else begin
                        pair = (pair & ~span) | ({wv, {BYTE_W{1'b0}}} >> off);
                        store_image[here]     = pair[PAIR_W-1 -: BYTE_W];
                        store_image[here + 1] = pair[BYTE_W-1:0];
                    end
                    reply.ok = 1'b1;
                    cur_byte = cur_byte + 1'b1;
                end
            end
            CMD_REWIND: begin
                cur_byte = '0;
                cur_bit  = '0;
                reply.ok = 1'b1;
            end
            default: begin
            end
        endcase
        reply.byte_pos = cur_byte;
        reply.bit_pos  = cur_bit;
    endtask

    // report one field that differs
    task automatic compare_field(input string field, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endtask

    // watch both channels and the register port at every edge
    always @(posedge aclk) begin : watch_channels
        reply_t want;
        reply_t reply;
        if (!aresetn) begin
            for (int i = 0; i < STORE_BYTES; i++) begin
                store_image[i] = '0;
            end
            cur_byte   = '0;
            cur_bit    = '0;
            stream_len = '0;
            pending_replies.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (m_valid && m_ready) begin
                checked_count++;
                if (pending_replies.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no item outstanding, ok %0d read %0d pos %0d.%0d",
                             $time, m_ok, m_read_value, m_byte_position, m_bit_position);
                end else begin
                    want = pending_replies.pop_front();
                    compare_field("ok", 16'(want.ok), 16'(m_ok));
                    compare_field("read_value", 16'(want.read_value), 16'(m_read_value));
                    compare_field("byte_position", 16'(want.byte_pos),
                                  16'(m_byte_position));
                    compare_field("bit_position", 16'(want.bit_pos), 16'(m_bit_position));
                end
            end
            if (cfg_wr_en) begin
                stream_len = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                step_cursor_model(s_command, s_write_value, reply);
                if (!reply.ok) begin
                    refused_count++;
                end
                pending_replies.push_back(reply);
            end
        end
        outstanding = pending_replies.size();
    end

endmodule

/* bench/bit_cursor_byte_store_core_tb.sv */
// stimulus, idling, watchdog and verdict for the bit cursor byte store core
module bit_cursor_byte_store_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcbs_pkg::*;

    localparam int unsigned STORE_BYTES      = 1024;
    localparam int unsigned CLK_PERIOD       = 20;
    localparam int unsigned RESET_CYCLES     = 9;
    localparam int unsigned STALL_LIMIT      = 4000;
    localparam int unsigned LONG_HOLD_CYCLES = 200;
    localparam int unsigned TAIL_CYCLES      = 8;
    localparam int unsigned MODE_SPAN        = 64;
    localparam int unsigned HOLD_AT          = 300;
    localparam int unsigned PAUSE_AT         = 600;
    localparam int unsigned LEN_ALL_ONES     = 2047;

    // codes outside the defined command set
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI  = 3'd7;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CURSOR_W-1:0] cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command     = '0;
    logic [BYTE_W-1:0]   s_write_value = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_ok;
    logic [BYTE_W-1:0]   m_read_value;
    logic [CURSOR_W-1:0] m_byte_position;
    logic [OFF_W-1:0]    m_bit_position;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned checked_count;
    int unsigned refused_count;

    int unsigned items_pushed;
    int unsigned length_settings;
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned long_holds_asked;
    int unsigned holds_served;
    int unsigned quiet_cycles;

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    bit_cursor_byte_store_core #(
        .STORE_BYTES(STORE_BYTES)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_write_value  (s_write_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_read_value   (m_read_value),
        .m_byte_position(m_byte_position),
        .m_bit_position (m_bit_position)
    );

    bcbs_cursor_checker #(
        .STORE_BYTES(STORE_BYTES)
    ) cursor_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_write_value  (s_write_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_read_value   (m_read_value),
        .m_byte_position(m_byte_position),
        .m_bit_position (m_bit_position),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .checked_count  (checked_count),
        .refused_count  (refused_count)
    );

    // result side: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != long_holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL bit_cursor_byte_store_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, with a random gap first, and hold it until taken
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wv);
        bit taken;
        // idling style rotates every few dozen items
        case (idle_mode_t'((items_pushed / MODE_SPAN) % 4))
            IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 80; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
            default:       begin sender_idle_pct = 10; recv_stall_pct = 10; end
        endcase
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_write_value <= wv;
        // ready is stable by the falling edge, so sample it there
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        items_pushed++;
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (outstanding != 0);
        @(posedge aclk);
    endtask

    // write the stream length register once the block is idle
    task automatic set_length(input int unsigned len);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CURSOR_W'(len);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        length_settings++;
    endtask

    // random items at one stream length; deep runs walk the cursor across the store
    task automatic run_phase(input int unsigned len, input int unsigned count,
                             input bit deep);
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] wv;
        int unsigned       pick;
        set_length(len);
        for (int unsigned i = 0; i < count; i++) begin
            if (deep && i == HOLD_AT) begin
                long_holds_asked++;
            end
            if (deep && i == PAUSE_AT) begin
                drain_replies();
            end
            pick = $urandom_range(99);
            if (deep) begin
                // mostly byte accesses, no rewind, so the cursor reaches the top
                if (pick < 45) begin
                    cmd = CMD_READ_BYTE;
                end else if (pick < 91) begin
                    cmd = CMD_WRITE_BYTE;
                end else if (pick < 93) begin
                    cmd = CMD_READ_BIT;
                end else if (pick < 95) begin
                    cmd = CMD_WRITE_BIT;
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
                end
            end else begin
                if (pick < 20) begin
                    cmd = CMD_READ_BIT;
                end else if (pick < 40) begin
                    cmd = CMD_READ_BYTE;
                end else if (pick < 60) begin
                    cmd = CMD_WRITE_BIT;
                end else if (pick < 85) begin
                    cmd = CMD_WRITE_BYTE;
                end else if (pick < 93) begin
                    cmd = CMD_REWIND;
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
                end
            end
            // bit writes clear half the time
            if (cmd == CMD_WRITE_BIT && $urandom_range(1) == 0) begin
                wv = '0;
            end else begin
                wv = BYTE_W'($urandom_range(255));
            end
            push_item(cmd, wv);
        end
    endtask

    // reset, directed cases, random phases, then the verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // empty stream: every access is refused
        set_length('0);
        push_item(CMD_READ_BIT, 8'h00);
        push_item(CMD_WRITE_BYTE, 8'hFF);
        push_item(CMD_REWIND, 8'h00);
        push_item(CMD_UNDEF_LO, 8'hFF);

        // two byte stream: aligned and unaligned access near the end
        set_length(2);
        push_item(CMD_WRITE_BYTE, 8'hFF);
        push_item(CMD_WRITE_BIT, 8'h00);
        push_item(CMD_WRITE_BIT, 8'h01);
        push_item(CMD_READ_BYTE, 8'h00);
        push_item(CMD_WRITE_BYTE, 8'h5A);
        push_item(CMD_REWIND, 8'h00);
        push_item(CMD_READ_BIT, 8'h00);
        push_item(CMD_READ_BYTE, 8'h00);
        push_item(CMD_REWIND, 8'h00);
        push_item(CMD_READ_BIT, 8'h00);
        push_item(CMD_WRITE_BYTE, 8'h81);
        push_item(CMD_REWIND, 8'h00);
        push_item(CMD_READ_BYTE, 8'h00);
        push_item(CMD_READ_BYTE, 8'h00);
        push_item(CMD_READ_BYTE, 8'h00);
        push_item(CMD_UNDEF_MID, 8'hFF);
        push_item(CMD_UNDEF_HI, 8'hAA);

        // length lowered below the cursor: refused until a rewind
        set_length(1);
        push_item(CMD_READ_BIT, 8'h00);
        push_item(CMD_WRITE_BIT, 8'hFF);
        push_item(CMD_REWIND, 8'h00);

        run_phase(3, 40, 1'b0);
        run_phase(1, 40, 1'b0);
        run_phase(LEN_ALL_ONES, 1150, 1'b1);
        run_phase(5, 50, 1'b0);
        run_phase(2, 40, 1'b0);
        run_phase(16, 50, 1'b0);
        run_phase(0, 30, 1'b0);
        run_phase(STORE_BYTES, 50, 1'b0);
        run_phase(7, 50, 1'b0);
        run_phase(4, 50, 1'b0);
        run_phase(1, 30, 1'b0);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items over %0d length settings, %0d results checked",
                 items_pushed, length_settings, checked_count);
        $display("%0d refused or unknown, %0d long result hold-offs, full store walk included",
                 refused_count, holds_served);
        if (fail_count == 0) begin
            $display("PASS bit_cursor_byte_store_core");
        end else begin
            $display("FAIL bit_cursor_byte_store_core");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bcbs_pkg.sv
hw/rtl/bcbs_bank.sv
hw/rtl/bcbs_cursor.sv
hw/rtl/bcbs_merge.sv
hw/rtl/bit_cursor_byte_store_core.sv
bench/bcbs_cursor_checker.sv
bench/bit_cursor_byte_store_core_tb.sv
